FILE: sv/plc_pkg.sv
// Shared widths, stage map, register codes and types of the Phong light contribution block.
package plc_pkg;

    // Fixed-point format and exponent width.
    localparam int FRAC_BITS = 14;
    localparam int EXP_BITS  = 8;

    // Field widths.
    localparam int VEC_W      = 16;
    localparam int COS_W      = 16;
    localparam int ATT_W      = 15;
    localparam int COL_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int HARD_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths, all derived from the field widths and FRAC_BITS.
    localparam int PROD_W  = 2 * VEC_W;
    localparam int NLS_W   = PROD_W + 2;
    localparam int NDL_W   = NLS_W - FRAC_BITS;
    localparam int T_W     = VEC_W + NDL_W + 1;
    localparam int R_W     = T_W - FRAC_BITS + 1;
    localparam int VR_W    = VEC_W + R_W;
    localparam int DS_W    = VR_W + 2;
    localparam int DOT_W   = DS_W - FRAC_BITS;
    localparam int BASE_W  = FRAC_BITS + 1;
    localparam int SQ_W    = 2 * BASE_W;
    localparam int CPOS_W  = COS_W - 1;
    localparam int DIFF_W  = CPOS_W + GAIN_W - FRAC_BITS;
    localparam int SPEC_W  = GAIN_W + BASE_W - FRAC_BITS;
    localparam int SUM_W   = ((DIFF_W > SPEC_W) ? DIFF_W : SPEC_W) + 1;
    localparam int AMT_W   = SUM_W + ATT_W - FRAC_BITS;
    localparam int CH_W    = COL_W + AMT_W - FRAC_BITS;

    localparam logic [BASE_W-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Pipeline stage map.
    localparam int STG_POW0   = 5;
    localparam int STG_SPEC   = STG_POW0 + 2 * EXP_BITS;
    localparam int STG_AMT    = STG_SPEC + 1;
    localparam int STG_OUT    = STG_AMT + 1;
    localparam int NUM_STAGES = STG_OUT + 1;
    localparam int CNT_W      = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_GREEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_BLUE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HARDNESS      = 3'd5;

    // Register reset values.
    localparam logic [COL_W-1:0]  LIGHT_RST    = 16'd256;
    localparam logic [GAIN_W-1:0] DIFF_GAIN_RST = 16'd16384;
    localparam logic [GAIN_W-1:0] SPEC_GAIN_RST = 16'd0;
    localparam logic [HARD_W-1:0] HARDNESS_RST  = 8'd16;

    typedef logic signed [VEC_W-1:0]  comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [R_W-1:0]    refl_t;
    typedef logic signed [VR_W-1:0]   vrprod_t;

    // Values that ride along with an item until the final scaling.
    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        logic [ATT_W-1:0]  atten;
    } side_t;

endpackage

FILE: sv/phong_light_contribution.sv
// Top level of the pipelined Phong light contribution datapath.
//
//  Channel | Signals                                   | Transfer when
//  --------+-------------------------------------------+------------------------------
//  input   | in_valid, in_ready, view/ldir/norm x,y,z, | in_valid && in_ready at clk
//          | cos_incidence, attenuation                |
//  output  | out_valid, out_ready, out_red/green/blue  | out_valid && out_ready at clk
//  config  | cfg_we, cfg_index, cfg_data               | cfg_we at clk
//
//  One item enters per cycle unless a stall holds stage 0; the pipeline is NUM_STAGES deep.
//  The depth is set by the specular power: one squaring stage and one multiply stage
//  per hardness bit, each with its own multiplier and register.
//  rst_n clears all valid bits and loads the register defaults; payload is not reset.
//  A stall only holds stages that are full and blocked; empty stages keep filling,
//  so the block takes new transfers while a finished result waits, until all are full.
module phong_light_contribution
    import plc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [VEC_W-1:0] view_x,
    input  logic signed [VEC_W-1:0] view_y,
    input  logic signed [VEC_W-1:0] view_z,
    input  logic signed [VEC_W-1:0] ldir_x,
    input  logic signed [VEC_W-1:0] ldir_y,
    input  logic signed [VEC_W-1:0] ldir_z,
    input  logic signed [VEC_W-1:0] norm_x,
    input  logic signed [VEC_W-1:0] norm_y,
    input  logic signed [VEC_W-1:0] norm_z,
    input  logic signed [COS_W-1:0] cos_incidence,
    input  logic [ATT_W-1:0]      attenuation,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COL_W-1:0]      out_red,
    output logic [COL_W-1:0]      out_green,
    output logic [COL_W-1:0]      out_blue,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers, read directly by every stage. The user
    // must change them only while the pipeline is empty; the block never checks.
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  light_red_reg;
    logic [COL_W-1:0]  light_green_reg;
    logic [COL_W-1:0]  light_blue_reg;
    logic [GAIN_W-1:0] diffuse_gain_reg;
    logic [GAIN_W-1:0] specular_gain_reg;
    logic [HARD_W-1:0] hardness_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_red_reg     <= LIGHT_RST;
            light_green_reg   <= LIGHT_RST;
            light_blue_reg    <= LIGHT_RST;
            diffuse_gain_reg  <= DIFF_GAIN_RST;
            specular_gain_reg <= SPEC_GAIN_RST;
            hardness_reg      <= HARDNESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LIGHT_RED:     light_red_reg     <= cfg_data[COL_W-1:0];
                REG_LIGHT_GREEN:   light_green_reg   <= cfg_data[COL_W-1:0];
                REG_LIGHT_BLUE:    light_blue_reg    <= cfg_data[COL_W-1:0];
                REG_DIFFUSE_GAIN:  diffuse_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_SPECULAR_GAIN: specular_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_HARDNESS:      hardness_reg      <= cfg_data[HARD_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. A stage advances when it is empty or when the
    // stage after it advances; the last stage is the output register.
    // ------------------------------------------------------------------
    logic vld_reg [NUM_STAGES];
    logic en      [NUM_STAGES];

    genvar gs;
    generate
        for (gs = 0; gs < NUM_STAGES - 1; gs++)
        begin : g_en
            assign en[gs] = !vld_reg[gs] || en[gs + 1];
        end
    endgenerate
    assign en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 0: products n.l per axis and the diffuse factor
    // (negative cosine counts as zero).
    // ------------------------------------------------------------------
    comp_t in_v [3];
    comp_t in_l [3];
    comp_t in_n [3];

    assign in_v[0] = view_x;
    assign in_v[1] = view_y;
    assign in_v[2] = view_z;
    assign in_l[0] = ldir_x;
    assign in_l[1] = ldir_y;
    assign in_l[2] = ldir_z;
    assign in_n[0] = norm_x;
    assign in_n[1] = norm_y;
    assign in_n[2] = norm_z;

    comp_t s0_v_reg  [3];
    comp_t s0_l_reg  [3];
    comp_t s0_n_reg  [3];
    prod_t s0_nl_reg [3];
    prod_t s0_nl_next [3];
    side_t s0_side_reg;
    side_t s0_side_next;

    logic [CPOS_W-1:0]        cos_pos;
    logic [CPOS_W+GAIN_W-1:0] diff_prod;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s0_nl_next[i] = in_n[i] * in_l[i];
        end
        cos_pos            = cos_incidence[COS_W-1] ? '0 : cos_incidence[CPOS_W-1:0];
        diff_prod          = cos_pos * diffuse_gain_reg;
        s0_side_next.diff  = diff_prod[CPOS_W+GAIN_W-1:FRAC_BITS];
        s0_side_next.atten = attenuation;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s0_v_reg[i]  <= in_v[i];
                s0_l_reg[i]  <= in_l[i];
                s0_n_reg[i]  <= in_n[i];
                s0_nl_reg[i] <= s0_nl_next[i];
            end
            s0_side_reg <= s0_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: ndl = floor(n.l / ONE). Taking the upper bits of a
    // two's complement sum is the floor shift.
    // ------------------------------------------------------------------
    comp_t s1_v_reg [3];
    comp_t s1_l_reg [3];
    comp_t s1_n_reg [3];
    logic signed [NDL_W-1:0] s1_ndl_reg;
    logic signed [NDL_W-1:0] s1_ndl_next;
    side_t s1_side_reg;

    logic signed [NLS_W-1:0] nl_sum;

    always_comb
    begin
        nl_sum = NLS_W'(s0_nl_reg[0]) + NLS_W'(s0_nl_reg[1]) + NLS_W'(s0_nl_reg[2]);
        s1_ndl_next = nl_sum[NLS_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_v_reg[i] <= s0_v_reg[i];
                s1_l_reg[i] <= s0_l_reg[i];
                s1_n_reg[i] <= s0_n_reg[i];
            end
            s1_ndl_reg  <= s1_ndl_next;
            s1_side_reg <= s0_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: reflected light r = l - floor(2 n ndl / ONE).
    // ------------------------------------------------------------------
    comp_t s2_v_reg [3];
    refl_t s2_r_reg [3];
    refl_t s2_r_next [3];
    side_t s2_side_reg;

    logic signed [T_W-2:0] nt   [3];
    logic signed [T_W-1:0] nt2  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nt[i]        = s1_n_reg[i] * s1_ndl_reg;
            nt2[i]       = {nt[i], 1'b0};
            s2_r_next[i] = R_W'(s1_l_reg[i]) - R_W'($signed(nt2[i][T_W-1:FRAC_BITS]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_v_reg[i] <= s1_v_reg[i];
                s2_r_reg[i] <= s2_r_next[i];
            end
            s2_side_reg <= s1_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: products v.r per axis.
    // ------------------------------------------------------------------
    vrprod_t s3_vr_reg  [3];
    vrprod_t s3_vr_next [3];
    side_t   s3_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_vr_next[i] = s2_v_reg[i] * s2_r_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s3_vr_reg[i] <= s3_vr_next[i];
            end
            s3_side_reg <= s2_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: base = floor(v.r / ONE), clamped to [0, ONE].
    // ------------------------------------------------------------------
    logic [BASE_W-1:0] s4_base_reg;
    logic [BASE_W-1:0] s4_base_next;
    side_t             s4_side_reg;

    logic signed [DS_W-1:0]  dot_sum;
    logic signed [DOT_W-1:0] dot;

    always_comb
    begin
        dot_sum = DS_W'(s3_vr_reg[0]) + DS_W'(s3_vr_reg[1]) + DS_W'(s3_vr_reg[2]);
        dot     = dot_sum[DS_W-1:FRAC_BITS];
        if (dot[DOT_W-1])
        begin
            s4_base_next = '0;
        end
        else if (dot[DOT_W-2:0] > (DOT_W-1)'(Q_ONE))
        begin
            s4_base_next = Q_ONE;
        end
        else
        begin
            s4_base_next = dot[BASE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_base_reg <= s4_base_next;
            s4_side_reg <= s3_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Power stages: for each hardness bit from the top, one stage squares
    // the accumulator and the next multiplies it by the base when the bit
    // is set. The accumulator never exceeds ONE.
    // ------------------------------------------------------------------
    logic [BASE_W-1:0] ps_acc_reg  [EXP_BITS];
    logic [BASE_W-1:0] ps_base_reg [EXP_BITS];
    side_t             ps_side_reg [EXP_BITS];
    logic [BASE_W-1:0] pm_acc_reg  [EXP_BITS];
    logic [BASE_W-1:0] pm_base_reg [EXP_BITS];
    side_t             pm_side_reg [EXP_BITS];

    genvar gk;
    generate
        for (gk = 0; gk < EXP_BITS; gk++)
        begin : g_pow
            localparam int SQ_STG  = STG_POW0 + 2 * gk;
            localparam int MUL_STG = SQ_STG + 1;
            localparam int HBIT    = EXP_BITS - 1 - gk;

            logic [BASE_W-1:0] acc_in;
            logic [BASE_W-1:0] base_in;
            side_t             side_in;
            logic              hbit;
            logic [SQ_W-1:0]   sq_prod;
            logic [SQ_W-1:0]   mul_prod;
            logic [BASE_W-1:0] sq_next;
            logic [BASE_W-1:0] mul_next;

            if (gk == 0)
            begin : g_first
                assign acc_in  = Q_ONE;
                assign base_in = s4_base_reg;
                assign side_in = s4_side_reg;
            end
            else
            begin : g_rest
                assign acc_in  = pm_acc_reg[gk-1];
                assign base_in = pm_base_reg[gk-1];
                assign side_in = pm_side_reg[gk-1];
            end

            if (HBIT < HARD_W)
            begin : g_bit
                assign hbit = hardness_reg[HBIT];
            end
            else
            begin : g_nobit
                assign hbit = 1'b0;
            end

            always_comb
            begin
                sq_prod  = acc_in * acc_in;
                sq_next  = sq_prod[FRAC_BITS+BASE_W-1:FRAC_BITS];
                mul_prod = ps_acc_reg[gk] * ps_base_reg[gk];
                mul_next = hbit ? mul_prod[FRAC_BITS+BASE_W-1:FRAC_BITS] : ps_acc_reg[gk];
            end

            always_ff @(posedge clk)
            begin
                if (en[SQ_STG])
                begin
                    ps_acc_reg[gk]  <= sq_next;
                    ps_base_reg[gk] <= base_in;
                    ps_side_reg[gk] <= side_in;
                end
                if (en[MUL_STG])
                begin
                    pm_acc_reg[gk]  <= mul_next;
                    pm_base_reg[gk] <= ps_base_reg[gk];
                    pm_side_reg[gk] <= ps_side_reg[gk];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Specular scaling and the sum with the diffuse factor. A zero
    // specular gain gives a zero specular term by itself.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [ATT_W-1:0] sum_atten_reg;

    logic [GAIN_W+BASE_W-1:0] spec_prod;
    logic [SPEC_W-1:0]        spec;

    always_comb
    begin
        spec_prod = specular_gain_reg * pm_acc_reg[EXP_BITS-1];
        spec      = spec_prod[GAIN_W+BASE_W-1:FRAC_BITS];
        sum_next  = SUM_W'(pm_side_reg[EXP_BITS-1].diff) + SUM_W'(spec);
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_SPEC])
        begin
            sum_reg       <= sum_next;
            sum_atten_reg <= pm_side_reg[EXP_BITS-1].atten;
        end
    end

    // ------------------------------------------------------------------
    // Light amount after attenuation.
    // ------------------------------------------------------------------
    logic [AMT_W-1:0]       amt_reg;
    logic [AMT_W-1:0]       amt_next;
    logic [SUM_W+ATT_W-1:0] amt_prod;

    always_comb
    begin
        amt_prod = sum_reg * sum_atten_reg;
        amt_next = amt_prod[SUM_W+ATT_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_AMT])
        begin
            amt_reg <= amt_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: each colour channel times the amount, saturated.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] colour [3];
    logic [COL_W-1:0] ch_reg  [3];
    logic [COL_W-1:0] ch_next [3];

    assign colour[0] = light_red_reg;
    assign colour[1] = light_green_reg;
    assign colour[2] = light_blue_reg;

    genvar gc;
    generate
        for (gc = 0; gc < 3; gc++)
        begin : g_ch
            logic [COL_W+AMT_W-1:0] ch_prod;
            logic [CH_W-1:0]        ch;

            assign ch_prod = colour[gc] * amt_reg;
            assign ch      = ch_prod[COL_W+AMT_W-1:FRAC_BITS];

            if (CH_W > COL_W)
            begin : g_sat
                assign ch_next[gc] = (|ch[CH_W-1:COL_W]) ? {COL_W{1'b1}} : ch[COL_W-1:0];
            end
            else
            begin : g_nosat
                assign ch_next[gc] = COL_W'(ch);
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en[STG_OUT])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ch_reg[i] <= ch_next[i];
            end
        end
    end

    assign out_red   = ch_reg[0];
    assign out_green = ch_reg[1];
    assign out_blue  = ch_reg[2];

endmodule

FILE: sv/plc_checker.sv
// Port-level checker for the Phong light contribution block, with its bind.
module plc_checker
    import plc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [COL_W-1:0] out_red,
    input logic [COL_W-1:0] out_green,
    input logic [COL_W-1:0] out_blue
);

    // Items taken in and not yet delivered.
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg + CNT_W'(in_valid && in_ready)
                        - CNT_W'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A result only appears for an item that was taken in.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result shown with no item in flight");

    // The pipeline never holds more items than it has stages.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(NUM_STAGES))
        else $error("more items in flight than pipeline stages");

    // With the output register empty, no stage can be blocked.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while output is empty");

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red)
            && $stable(out_green) && $stable(out_blue))
        else $error("waiting result dropped or changed");

endmodule

bind phong_light_contribution plc_checker u_plc_checker (.*);
